// ===== hw/rtl/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// Shared types and constants for the I2C master byte sequencer: command
// codes, sequencer phases, the ack timeout reset value and the last bit.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

  // Command codes carried on a tick
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WACK  = 3'd5
  } cmd_t;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_B   = 5'd1,
    PH_ST_C   = 5'd2,
    PH_SP_B   = 5'd3,
    PH_SP_BE  = 5'd4,
    PH_W_HI   = 5'd5,
    PH_W_LO   = 5'd6,
    PH_W_SET  = 5'd7,
    PH_W_TAIL = 5'd8,
    PH_R_HI   = 5'd9,
    PH_R_LO   = 5'd10,
    PH_R_ACK  = 5'd11,
    PH_R_AH   = 5'd12,
    PH_R_END  = 5'd13,
    PH_A_HI   = 5'd14,
    PH_A_POLL = 5'd15
  } phase_t;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [2:0] LAST_BIT        = 3'd7;

endpackage

// ===== hw/rtl/i2c_master_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Bit-level I2C master sequencer: one request is one bus timing tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick per request: a command
//   (taken only while idle), the byte to write, the ACK/NACK choice for a
//   read and the sampled SDA level. Commands arriving while busy are ignored.
//   Result channel (out_valid/out_ready) returns one result per tick: the
//   SCL/SDA levels and SDA enable driven during that tick, busy, done, the
//   last received byte and the ack-timeout error flag.
//   A tick's result is registered and shown in the cycle after accept;
//   throughput is one tick per clock while results are taken, set by the
//   single result register after the next-state logic. A new tick is taken
//   while a result is held if the receiver takes it in the same cycle.
//   cfg_we/cfg_wdata write the ack timeout limit (reset 250).
//   Synchronous reset: idle, SCL low, SDA high and driven, counters zero,
//   received byte zero, result channel empty.
//   When the receiver stalls, in_ready drops and all sequencer state holds.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // tick input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_tx_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_sample,
  // tick result
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_sda_enable,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_error
);
  import i2cmbs_pkg::*;

  // state registers
  phase_t     phase_r,   phase_nxt;
  logic [2:0] bitcnt_r,  bitcnt_nxt;
  logic [7:0] shift_r,   shift_nxt;
  logic [7:0] poll_r,    poll_nxt;
  logic       scl_r,     scl_nxt;
  logic       sda_r,     sda_nxt;
  logic       en_r,      en_nxt;
  logic       ackc_r,    ackc_nxt;
  logic [7:0] rx_r,      rx_nxt;
  logic [7:0] limit_r;

  // result registers
  logic       out_valid_r;
  logic       busy_r,    busy_nxt;
  logic       done_r,    done_nxt;
  logic       err_r,     err_nxt;

  logic       accept;
  logic [7:0] poll_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign poll_inc = poll_r + 8'd1;

  // next state and result of one tick
  always_comb begin
    phase_nxt  = phase_r;
    bitcnt_nxt = bitcnt_r;
    shift_nxt  = shift_r;
    poll_nxt   = poll_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    en_nxt     = en_r;
    ackc_nxt   = ackc_r;
    rx_nxt     = rx_r;
    busy_nxt   = 1'b1;
    done_nxt   = 1'b0;
    err_nxt    = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        busy_nxt = 1'b0;
        case (in_cmd)
          CMD_START: begin
            en_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
            phase_nxt = PH_ST_B; busy_nxt = 1'b1;
          end
          CMD_STOP: begin
            en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
            phase_nxt = PH_SP_B; busy_nxt = 1'b1;
          end
          CMD_WRITE: begin
            en_nxt = 1'b1; scl_nxt = 1'b0;
            sda_nxt = in_tx_byte[7];
            shift_nxt = {in_tx_byte[6:0], 1'b0};
            bitcnt_nxt = '0;
            phase_nxt = PH_W_HI; busy_nxt = 1'b1;
          end
          CMD_READ: begin
            en_nxt = 1'b0; scl_nxt = 1'b0;
            shift_nxt = '0; bitcnt_nxt = '0;
            ackc_nxt = in_send_ack;
            phase_nxt = PH_R_HI; busy_nxt = 1'b1;
          end
          CMD_WACK: begin
            en_nxt = 1'b0; sda_nxt = 1'b1;
            poll_nxt = '0;
            phase_nxt = PH_A_HI; busy_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      PH_ST_B: begin
        sda_nxt = 1'b0; phase_nxt = PH_ST_C;
      end
      PH_ST_C: begin
        scl_nxt = 1'b0; done_nxt = 1'b1;
      end
      PH_SP_B, PH_SP_BE: begin
        err_nxt = (phase_r == PH_SP_BE);
        scl_nxt = 1'b1; sda_nxt = 1'b1; done_nxt = 1'b1;
      end
      PH_W_HI: begin
        scl_nxt = 1'b1; phase_nxt = PH_W_LO;
      end
      PH_W_LO: begin
        scl_nxt = 1'b0;
        if (bitcnt_r == LAST_BIT) begin
          phase_nxt = PH_W_TAIL;
        end else begin
          bitcnt_nxt = bitcnt_r + 3'd1;
          phase_nxt = PH_W_SET;
        end
      end
      PH_W_SET: begin
        sda_nxt = shift_r[7];
        shift_nxt = {shift_r[6:0], 1'b0};
        phase_nxt = PH_W_HI;
      end
      PH_W_TAIL: begin
        done_nxt = 1'b1;
      end
      PH_R_HI: begin
        scl_nxt = 1'b1;
        shift_nxt = {shift_r[6:0], in_sda_sample};
        if (bitcnt_r == LAST_BIT) begin
          phase_nxt = PH_R_ACK;
        end else begin
          bitcnt_nxt = bitcnt_r + 3'd1;
          phase_nxt = PH_R_LO;
        end
      end
      PH_R_LO: begin
        scl_nxt = 1'b0; phase_nxt = PH_R_HI;
      end
      PH_R_ACK: begin
        scl_nxt = 1'b0; en_nxt = 1'b1; sda_nxt = !ackc_r;
        phase_nxt = PH_R_AH;
      end
      PH_R_AH: begin
        scl_nxt = 1'b1; phase_nxt = PH_R_END;
      end
      PH_R_END: begin
        scl_nxt = 1'b0; rx_nxt = shift_r; done_nxt = 1'b1;
      end
      PH_A_HI: begin
        scl_nxt = 1'b1; phase_nxt = PH_A_POLL;
      end
      PH_A_POLL: begin
        if (!in_sda_sample) begin
          scl_nxt = 1'b0; done_nxt = 1'b1;
        end else begin
          poll_nxt = poll_inc;
          // timeout: abort with a stop condition
          if (poll_inc > limit_r) begin
            en_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
            phase_nxt = PH_SP_BE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE; busy_nxt = 1'b0;
      end
    endcase
    if (done_nxt) begin
      busy_nxt = 1'b0;
      phase_nxt = PH_IDLE;
    end
  end

  // timeout limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bitcnt_r <= '0;
      shift_r  <= '0;
      poll_r   <= '0;
      scl_r    <= 1'b0;
      sda_r    <= 1'b1;
      en_r     <= 1'b1;
      ackc_r   <= 1'b0;
      rx_r     <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      bitcnt_r <= bitcnt_nxt;
      shift_r  <= shift_nxt;
      poll_r   <= poll_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      en_r     <= en_nxt;
      ackc_r   <= ackc_nxt;
      rx_r     <= rx_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result flags
  always_ff @(posedge clk) begin
    if (accept) begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = scl_r;
  assign out_sda_level  = sda_r;
  assign out_sda_enable = en_r;
  assign out_busy_res   = busy_r;
  assign out_done_res   = done_r;
  assign out_rx_byte    = rx_r;
  assign out_ack_error  = err_r;

  // checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(done_r && busy_r))
    else $error("done and busy reported together");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> done_r)
    else $error("ack error without done");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(phase_r) && $stable(shift_r) && $stable(poll_r))
    else $error("state moved without an accepted tick");

  a_read_released: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_R_HI) |=> !en_r)
    else $error("SDA driven while reading data bits");

  a_start_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_ST_C) |=> (phase_r == PH_IDLE) && done_r)
    else $error("start did not finish");

endmodule
